### rtl/core/lrsp_pkg.sv
// ----------------------------------------------------------------------------
// Least-recently-seen target picker package
// Shared types and constants for the picker, its history chain and its cells.
// ----------------------------------------------------------------------------
package lrsp_pkg;

  localparam int unsigned IdW   = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned IdxW  = 6;

  localparam logic [IdxW-1:0]  IdxMax        = 6'd63;
  localparam logic [TimeW-1:0] ThreshResetMs = 32'd10000;

  typedef enum logic {
    CMD_ITEM = 1'b0,
    CMD_END  = 1'b1
  } lrsp_cmd_e;

  typedef struct packed {
    lrsp_cmd_e          command;
    logic [IdW-1:0]     entity_id;
    logic [TimeW-1:0]   now_ms;
  } lrsp_req_t;

  typedef struct packed {
    logic               target_found;
    logic [IdW-1:0]     target_id;
    logic [IdxW-1:0]    target_index;
  } lrsp_rsp_t;

  typedef struct packed {
    logic               push;
    logic [IdW-1:0]     id;
    logic [TimeW-1:0]   time_ms;
  } lrsp_push_t;

  typedef struct packed {
    logic               hit;
    logic [TimeW-1:0]   time_ms;
  } lrsp_hit_t;

endpackage

### rtl/core/lrsp_cell.sv
// ----------------------------------------------------------------------------
// History cell
// Holds one history entry, shifts in its neighbor's entry on a push and
// extends the newest-first match chain with its own comparison.
// ----------------------------------------------------------------------------
module lrsp_cell (
  input  logic                      clk_i,
  input  logic                      push_i,
  input  logic                      valid_i,
  input  logic [lrsp_pkg::IdW-1:0]  key_i,
  input  logic [lrsp_pkg::IdW-1:0]  prev_id_i,
  input  logic [lrsp_pkg::TimeW-1:0] prev_time_i,
  input  lrsp_pkg::lrsp_hit_t       hit_i,
  output logic [lrsp_pkg::IdW-1:0]  id_o,
  output logic [lrsp_pkg::TimeW-1:0] time_o,
  output lrsp_pkg::lrsp_hit_t       hit_o
);
  import lrsp_pkg::*;

  logic [IdW-1:0]   id_q;
  logic [TimeW-1:0] time_q;
  logic             match;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      id_q   <= prev_id_i;
      time_q <= prev_time_i;
    end
  end

  assign match         = valid_i && (id_q == key_i);
  assign hit_o.hit     = hit_i.hit || match;
  assign hit_o.time_ms = hit_i.hit ? hit_i.time_ms : time_q;
  assign id_o          = id_q;
  assign time_o        = time_q;

endmodule

### rtl/core/lrsp_chain.sv
// ----------------------------------------------------------------------------
// History chain
// A row of history cells, newest first, with the fill count that marks
// which cells hold entries.
// ----------------------------------------------------------------------------
module lrsp_chain #(
  parameter int unsigned HISTORY_DEPTH = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lrsp_pkg::lrsp_push_t      push_i,
  input  logic [lrsp_pkg::IdW-1:0]  key_i,
  output lrsp_pkg::lrsp_hit_t       hit_o
);
  import lrsp_pkg::*;

  localparam int unsigned CntW = $clog2(HISTORY_DEPTH + 1);

  logic [CntW-1:0]  count_q, count_d;
  logic [IdW-1:0]   ids   [HISTORY_DEPTH+1];
  logic [TimeW-1:0] times [HISTORY_DEPTH+1];
  lrsp_hit_t        hits  [HISTORY_DEPTH+1];

  assign ids[0]           = push_i.id;
  assign times[0]         = push_i.time_ms;
  assign hits[0].hit      = 1'b0;
  assign hits[0].time_ms  = '0;

  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    lrsp_cell u_cell (
      .clk_i       (clk_i),
      .push_i      (push_i.push),
      .valid_i     (count_q > CntW'(g)),
      .key_i       (key_i),
      .prev_id_i   (ids[g]),
      .prev_time_i (times[g]),
      .hit_i       (hits[g]),
      .id_o        (ids[g+1]),
      .time_o      (times[g+1]),
      .hit_o       (hits[g+1])
    );
  end

  assign hit_o = hits[HISTORY_DEPTH];

  always_comb begin
    count_d = count_q;
    if (push_i.push && (count_q < CntW'(HISTORY_DEPTH))) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(HISTORY_DEPTH))
    else $error("History count exceeds the depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push && (count_q < CntW'(HISTORY_DEPTH)) |=> count_q == $past(count_q) + CntW'(1))
    else $error("History count did not grow on a push.");

endmodule

### rtl/core/least_recently_seen_target_picker_unit.sv
// ----------------------------------------------------------------------------
// Least-recently-seen target picker
// Scans a priority-ordered candidate list and picks the first id absent from
// the pick history, or else the oldest-seen candidate older than a threshold.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  req     | in        | req_valid_i / req_stall_o   | req_i (lrsp_req_t)
//  rsp     | out       | rsp_valid_o / rsp_stall_i   | rsp_o (lrsp_rsp_t)
//  cfg     | in        | cfg_we_i                    | cfg_wdata_i (threshold)
//
// All history cells compare against a request combinationally, as it is accepted.
// A result is held in an output register, and the next request is taken
// while it waits unless that register is stalled.
// The reset is asynchronous and clears the history count and list state.
// ----------------------------------------------------------------------------
module least_recently_seen_target_picker_unit #(
  parameter int unsigned HISTORY_DEPTH = 10,
  parameter int unsigned MAX_LIST      = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_stall_o,
  input  lrsp_pkg::lrsp_req_t         req_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_stall_i,
  output lrsp_pkg::lrsp_rsp_t         rsp_o,
  input  logic                        cfg_we_i,
  input  logic [lrsp_pkg::TimeW-1:0]  cfg_wdata_i
);
  import lrsp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_LIST + 1);

  logic [TimeW-1:0] thresh_q;
  logic             active_q, active_d;
  logic             decided_q, decided_d;
  logic [TimeW-1:0] list_now_q, list_now_d;
  logic [TimeW-1:0] best_time_q, best_time_d;
  logic [IdW-1:0]   best_id_q, best_id_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic [IdxW-1:0]  pos_q, pos_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             rsp_valid_q;
  lrsp_rsp_t        rsp_q;

  logic             accept;
  logic             res_valid;
  lrsp_rsp_t        res;
  lrsp_push_t       push;
  lrsp_hit_t        hit;

  logic             e_decided;
  logic [TimeW-1:0] e_now, e_best_time;
  logic [IdxW-1:0]  e_pos;
  logic [CntW-1:0]  e_cnt;

  assign req_stall_o = rsp_valid_q && rsp_stall_i;
  assign accept      = req_valid_i && !req_stall_o;

  lrsp_chain #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .key_i  (req_i.entity_id),
    .hit_o  (hit)
  );

  always_comb begin
    e_decided   = active_q ? decided_q : 1'b0;
    e_now       = active_q ? list_now_q : req_i.now_ms;
    e_best_time = active_q ? best_time_q : req_i.now_ms;
    e_pos       = active_q ? pos_q : '0;
    e_cnt       = active_q ? cnt_q : '0;

    active_d    = active_q;
    decided_d   = decided_q;
    list_now_d  = list_now_q;
    best_time_d = best_time_q;
    best_id_d   = best_id_q;
    best_idx_d  = best_idx_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    res_valid   = 1'b0;
    res         = '0;
    push        = '0;

    if (accept) begin
      case (req_i.command)
        CMD_END: begin
          if (!active_q) begin
            res_valid = 1'b1;
          end else begin
            if (!decided_q) begin
              res_valid = 1'b1;
              if ((list_now_q - best_time_q) > thresh_q) begin
                res.target_found = 1'b1;
                res.target_id    = best_id_q;
                res.target_index = best_idx_q;
                push.push        = 1'b1;
                push.id          = best_id_q;
                push.time_ms     = list_now_q;
              end
            end
            active_d  = 1'b0;
            decided_d = 1'b0;
            pos_d     = '0;
            cnt_d     = '0;
          end
        end
        CMD_ITEM: begin
          active_d = 1'b1;
          if (!active_q) begin
            list_now_d  = req_i.now_ms;
            decided_d   = 1'b0;
            best_time_d = req_i.now_ms;
            best_id_d   = '0;
            best_idx_d  = '0;
            pos_d       = '0;
            cnt_d       = '0;
          end
          if (!e_decided && (e_cnt < CntW'(MAX_LIST))) begin
            cnt_d = e_cnt + CntW'(1);
            pos_d = (e_pos < IdxMax) ? e_pos + IdxW'(1) : e_pos;
            if (!hit.hit) begin
              decided_d        = 1'b1;
              res_valid        = 1'b1;
              res.target_found = 1'b1;
              res.target_id    = req_i.entity_id;
              res.target_index = e_pos;
              push.push        = 1'b1;
              push.id          = req_i.entity_id;
              push.time_ms     = e_now;
            end else if ((e_now - hit.time_ms) > (e_now - e_best_time)) begin
              best_time_d = hit.time_ms;
              best_id_d   = req_i.entity_id;
              best_idx_d  = e_pos;
            end
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= ThreshResetMs;
      active_q    <= 1'b0;
      decided_q   <= 1'b0;
      list_now_q  <= '0;
      best_time_q <= '0;
      best_id_q   <= '0;
      best_idx_q  <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      active_q    <= active_d;
      decided_q   <= decided_d;
      list_now_q  <= list_now_d;
      best_time_q <= best_time_d;
      best_id_q   <= best_id_d;
      best_idx_q  <= best_idx_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      if (res_valid) begin
        rsp_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      rsp_q <= res;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    decided_q |-> active_q)
    else $error("Early pick is marked with no open list.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.target_found |-> rsp_o.target_id == '0 && rsp_o.target_index == '0)
    else $error("An empty result carries a target.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && decided_q && accept && req_i.command == CMD_ITEM |-> !res_valid && !push.push)
    else $error("A request after an early pick produced a result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push |-> res_valid && res.target_found)
    else $error("History push without a found target.");

endmodule
